// ===== rtl/core/tmpr_pkg.sv =====
// shared types and constants for the text mode pixel renderer
// no dependencies; used by every module of the block except tmpr_checker
`default_nettype none

package tmpr_pkg;

  // item actions
  typedef logic [1:0] action_t;
  localparam action_t ACT_WR_CHAR  = 2'd0;
  localparam action_t ACT_WR_TINT  = 2'd1;
  localparam action_t ACT_WR_FONT  = 2'd2;
  localparam action_t ACT_RENDER   = 2'd3;

  // configuration register indexes
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_DISPLAY_ENABLE = 2'd0;
  localparam cfg_index_t CFG_GLOBAL_INVERT  = 2'd1;
  localparam cfg_index_t CFG_FONT_BASE      = 2'd2;

  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam logic [23:0] LOW_ONES = 24'h070707;

  typedef struct packed {
    logic        display_enable;
    logic        global_invert;
    logic [15:0] font_base;
  } cfg_t;

  // one classified word handed from front to back
  typedef struct packed {
    action_t     op;
    logic [15:0] addr;    // cell index for renders, write address otherwise
    logic [15:0] data;
    logic [2:0]  px;
    logic [2:0]  py;
    logic        active;  // render inside text area with display on
  } entry_t;

  function automatic logic [23:0] tint_color(input logic [15:0] tint);
    tint_color = {tint[4:0], 3'b000, tint[9:5], 3'b000, tint[14:10], 3'b000} | LOW_ONES;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/text_mode_pixel_renderer.sv =====
// top level of the text mode pixel renderer: config registers, front, queue, back
// depends on tmpr_pkg, tmpr_front, tmpr_queue, tmpr_back
`default_nettype none

// Text mode pixel renderer. Each input word either writes a character code,
// a cell tint or a font byte, or asks for the color of one pixel; only pixel
// requests produce an output word. While out_stall stays low the block
// sustains one word per clock on both sides. A pixel request goes through a
// one stage front end (cell and glyph position by reciprocal multiply), a four
// entry queue, and a four stage back end (character and tint store read, font
// address add, font store read, color). Store writes travel the same path and
// land at the stage that reads that store, so reads always see every earlier
// write. in_stall rises only when the queue is full; out_stall freezes the back
// end while an output word waits. Stores come up undefined and must be written
// before they are read. The user must write configuration only while the block
// is idle, through cfg_wr_en/cfg_index/cfg_wdata; the block does not enforce it.
module text_mode_pixel_renderer #(
  parameter int COLS           = 32,
  parameter int ROWS           = 8,
  parameter int ROW_STRIDE     = 32,
  parameter int GLYPH_WIDTH    = 8,
  parameter int GLYPH_HEIGHT   = 8,
  parameter int FONT_ADDR_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [15:0] in_write_address,
  input  wire logic [15:0] in_write_data,
  input  wire logic [7:0]  in_pixel_x,
  input  wire logic [5:0]  in_pixel_y,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_pixel_color,
  output logic             out_pixel_on
);

  tmpr_pkg::cfg_t   cfg_r;

  logic             queue_full;
  logic             push;
  tmpr_pkg::entry_t push_entry;
  logic             q_pop;
  logic             q_not_empty;
  tmpr_pkg::entry_t q_head;

  // configuration registers, indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tmpr_pkg::CFG_DISPLAY_ENABLE: cfg_r.display_enable <= cfg_wdata[0];
        tmpr_pkg::CFG_GLOBAL_INVERT:  cfg_r.global_invert  <= cfg_wdata[0];
        tmpr_pkg::CFG_FONT_BASE:      cfg_r.font_base      <= cfg_wdata;
        default:                      cfg_r                <= cfg_r;
      endcase
    end
  end

  // front: accept and classify each word
  tmpr_front #(
    .COLS         (COLS),
    .ROWS         (ROWS),
    .ROW_STRIDE   (ROW_STRIDE),
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_write_address (in_write_address),
    .in_write_data    (in_write_data),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .display_enable   (cfg_r.display_enable),
    .queue_full       (queue_full),
    .push             (push),
    .push_entry       (push_entry)
  );

  // decoupling queue
  tmpr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // back: stores, glyph fetch and color
  tmpr_back #(
    .FONT_ADDR_BITS (FONT_ADDR_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_color (out_pixel_color),
    .out_pixel_on    (out_pixel_on)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tmpr_front.sv =====
// front end: accepts input words, locates the text cell and glyph position
// depends on tmpr_pkg
`default_nettype none

module tmpr_front #(
  parameter int COLS         = 32,
  parameter int ROWS         = 8,
  parameter int ROW_STRIDE   = 32,
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_action,
  input  wire logic [15:0]       in_write_address,
  input  wire logic [15:0]       in_write_data,
  input  wire logic [7:0]        in_pixel_x,
  input  wire logic [5:0]        in_pixel_y,
  input  wire logic              display_enable,
  input  wire logic              queue_full,
  output logic                   push,
  output tmpr_pkg::entry_t       push_entry
);

  // reciprocal constants for the quotient by glyph size
  localparam int XRECIP = (65536 + GLYPH_WIDTH - 1) / GLYPH_WIDTH;
  localparam int YRECIP = (65536 + GLYPH_HEIGHT - 1) / GLYPH_HEIGHT;
  localparam int XLIM   = COLS * GLYPH_WIDTH;
  localparam int YLIM   = ROWS * GLYPH_HEIGHT;

  logic        f_valid_r;
  logic [1:0]  f_act_r;
  logic [15:0] f_waddr_r;
  logic [15:0] f_wdata_r;
  logic [7:0]  f_col_r;
  logic [5:0]  f_row_r;
  logic [7:0]  f_x_r;
  logic [5:0]  f_y_r;
  logic        f_active_r;

  logic        f_adv;
  logic [24:0] x_prod;
  logic [24:0] y_prod;
  logic        in_area;
  logic [15:0] cell_sum;
  logic [7:0]  x_base;
  logic [7:0]  x_diff;
  logic [5:0]  y_base;
  logic [5:0]  y_diff;

  assign f_adv    = !f_valid_r || !queue_full;
  assign in_stall = !f_adv;
  assign push     = f_valid_r && !queue_full;

  assign x_prod  = 25'(in_pixel_x) * 25'(XRECIP);
  assign y_prod  = 25'(in_pixel_y) * 25'(YRECIP);
  assign in_area = (12'(in_pixel_x) < 12'(XLIM)) && (12'(in_pixel_y) < 12'(YLIM));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (f_adv) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv) begin
      f_act_r    <= in_action;
      f_waddr_r  <= in_write_address;
      f_wdata_r  <= in_write_data;
      f_col_r    <= x_prod[23:16];
      f_row_r    <= y_prod[21:16];
      f_x_r      <= in_pixel_x;
      f_y_r      <= in_pixel_y;
      f_active_r <= in_area && display_enable;
    end
  end

  // cell index and position inside the glyph
  assign cell_sum = 16'(f_row_r) * 16'(ROW_STRIDE) + 16'(f_col_r);
  assign x_base   = 8'(16'(f_col_r) * 16'(GLYPH_WIDTH));
  assign y_base   = 6'(16'(f_row_r) * 16'(GLYPH_HEIGHT));
  assign x_diff   = f_x_r - x_base;
  assign y_diff   = f_y_r - y_base;

  always_comb begin
    push_entry.op     = f_act_r;
    push_entry.data   = f_wdata_r;
    push_entry.px     = x_diff[2:0];
    push_entry.py     = y_diff[2:0];
    push_entry.active = f_active_r;
    unique case (f_act_r)
      tmpr_pkg::ACT_RENDER: push_entry.addr = {8'd0, cell_sum[7:0]};
      default:              push_entry.addr = f_waddr_r;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/tmpr_queue.sv =====
// short word queue between front and back ends
// depends on tmpr_pkg
`default_nettype none

module tmpr_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  tmpr_pkg::entry_t      push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output tmpr_pkg::entry_t      head
);

  tmpr_pkg::entry_t                  slot_r [tmpr_pkg::QUEUE_DEPTH];
  logic [tmpr_pkg::QUEUE_PTR_W-1:0]  wr_ptr_r;
  logic [tmpr_pkg::QUEUE_PTR_W-1:0]  rd_ptr_r;
  logic [tmpr_pkg::QUEUE_PTR_W:0]    count_r;

  assign full      = count_r == (tmpr_pkg::QUEUE_PTR_W+1)'(tmpr_pkg::QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule

`default_nettype wire

// ===== rtl/core/tmpr_back.sv =====
// back end: store writes, cell and glyph fetch, color and output register
// depends on tmpr_pkg
`default_nettype none

module tmpr_back #(
  parameter int FONT_ADDR_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  tmpr_pkg::cfg_t        cfg,
  input  wire logic             q_not_empty,
  input  tmpr_pkg::entry_t      q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [23:0]           out_pixel_color,
  output logic                  out_pixel_on
);

  localparam int FONT_DEPTH = 2 ** FONT_ADDR_BITS;

  logic [7:0]  char_mem [256];
  logic [15:0] tint_mem [256];
  logic [7:0]  font_mem [FONT_DEPTH];

  logic        adv;

  // stage 1: cell stores read
  logic        b1_valid_r;
  logic [1:0]  b1_op_r;
  logic [15:0] b1_addr_r;
  logic [7:0]  b1_wdata_r;
  logic [2:0]  b1_px_r;
  logic [2:0]  b1_py_r;
  logic        b1_active_r;
  logic [7:0]  b1_code_r;
  logic [15:0] b1_tint_r;

  // stage 2: font address ready
  logic                      b2_valid_r;
  logic [1:0]                b2_op_r;
  logic [FONT_ADDR_BITS-1:0] b2_faddr_r;
  logic [7:0]                b2_wdata_r;
  logic [2:0]                b2_px_r;
  logic                      b2_active_r;
  logic [15:0]               b2_tint_r;

  // stage 3: glyph byte read
  logic        b3_valid_r;
  logic [1:0]  b3_op_r;
  logic [2:0]  b3_px_r;
  logic        b3_active_r;
  logic [15:0] b3_tint_r;
  logic [7:0]  b3_glyph_r;

  logic        out_valid_r;
  logic [23:0] out_color_r;
  logic        out_on_r;

  logic [16:0] faddr_sum;
  logic        glyph_bit;
  logic        pix_on;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_not_empty;

  assign faddr_sum = 17'(cfg.font_base) + 17'({b1_code_r, 3'b000}) + 17'(b1_py_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      b3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b1_valid_r  <= q_not_empty;
      b2_valid_r  <= b1_valid_r;
      b3_valid_r  <= b2_valid_r;
      out_valid_r <= b3_valid_r && (b3_op_r == tmpr_pkg::ACT_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_op_r     <= q_head.op;
      b1_addr_r   <= q_head.addr;
      b1_wdata_r  <= q_head.data[7:0];
      b1_px_r     <= q_head.px;
      b1_py_r     <= q_head.py;
      b1_active_r <= q_head.active;

      b2_op_r     <= b1_op_r;
      b2_wdata_r  <= b1_wdata_r;
      b2_px_r     <= b1_px_r;
      b2_active_r <= b1_active_r;
      b2_tint_r   <= b1_tint_r;
      if (b1_op_r == tmpr_pkg::ACT_WR_FONT) begin
        b2_faddr_r <= b1_addr_r[FONT_ADDR_BITS-1:0];
      end else begin
        b2_faddr_r <= faddr_sum[FONT_ADDR_BITS-1:0];
      end

      b3_op_r     <= b2_op_r;
      b3_px_r     <= b2_px_r;
      b3_active_r <= b2_active_r;
      b3_tint_r   <= b2_tint_r;

      out_color_r <= pix_on ? tmpr_pkg::tint_color(b3_tint_r) : 24'd0;
      out_on_r    <= pix_on;
    end
  end

  // cell stores: writes and reads in the same stage keep item order
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_head.op == tmpr_pkg::ACT_WR_CHAR) char_mem[q_head.addr[7:0]] <= q_head.data[7:0];
      if (q_head.op == tmpr_pkg::ACT_WR_TINT) tint_mem[q_head.addr[7:0]] <= q_head.data;
      b1_code_r <= char_mem[q_head.addr[7:0]];
      b1_tint_r <= tint_mem[q_head.addr[7:0]];
    end
  end

  // font store
  always_ff @(posedge clk) begin
    if (adv && b2_valid_r) begin
      if (b2_op_r == tmpr_pkg::ACT_WR_FONT) font_mem[b2_faddr_r] <= b2_wdata_r;
      b3_glyph_r <= font_mem[b2_faddr_r];
    end
  end

  assign glyph_bit = b3_glyph_r[3'd7 - b3_px_r];
  assign pix_on    = b3_active_r && (glyph_bit ^ cfg.global_invert ^ b3_tint_r[15]);

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;
  assign out_pixel_on    = out_on_r;

endmodule

`default_nettype wire

// ===== rtl/core/tmpr_checker.sv =====
// port level checks for the text mode pixel renderer, bound to the top level
// depends on text_mode_pixel_renderer ports only
`default_nettype none

module tmpr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] out_pixel_color,
  input wire logic        out_pixel_on
);

  // a stalled output word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // background pixels are black
  a_off_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_on |-> out_pixel_color == 24'd0)
    else $error("off pixel with nonzero color");

  // foreground colors carry ones in the low bits of each channel
  a_on_low_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_on |->
      out_pixel_color[2:0] == 3'b111 && out_pixel_color[10:8] == 3'b111 &&
      out_pixel_color[18:16] == 3'b111)
    else $error("on pixel color malformed");

  // reset empties the output side
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word after reset");

endmodule

bind text_mode_pixel_renderer tmpr_checker u_tmpr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pixel_color (out_pixel_color),
  .out_pixel_on    (out_pixel_on)
);

`default_nettype wire
